>>> hw/rtl/utc_pkg.sv
// Shared types, constants and helper functions of the UTCTime encoder.
`default_nettype none

package utc_pkg;

    localparam int unsigned PC_W = 5;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc PC_IDLE = t_pc'(0);

    localparam logic [7:0] UTC_TAG  = 8'h17;
    localparam logic [7:0] UTC_LEN  = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_Z     = 8'h5A;

    // Calendar position of the epoch year 1970
    localparam logic [1:0] EPOCH_Y4   = 2'd2;
    localparam logic [6:0] EPOCH_Y100 = 7'd70;
    localparam logic [8:0] EPOCH_Y400 = 9'd370;

    localparam logic [6:0] Y100_MAX = 7'd99;
    localparam logic [8:0] Y400_MAX = 9'd399;
    localparam logic [3:0] MON_JAN  = 4'd1;
    localparam logic [3:0] MON_DEC  = 4'd12;
    localparam logic [8:0] DAYS_YEAR = 9'd365;
    localparam logic [8:0] DAYS_LEAP = 9'd366;

    // Reciprocals for the constant divides: ceil(2^37 / 60) and ceil(2^36 / 24).
    // The first is exact for any 32-bit dividend, the second for hour counts
    // below 2^32 / 3600.
    localparam logic [31:0] RECIP_MIN_SEC = 32'h8888_8889;
    localparam logic [31:0] RECIP_HOUR    = 32'hAAAA_AAAB;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_DIV,
        OP_YEAR,
        OP_MONTH,
        OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        DST_SEC,
        DST_MIN,
        DST_HOUR
    } t_dst;

    typedef enum logic [3:0] {
        SRC_TAG,
        SRC_LEN,
        SRC_YY_HI,
        SRC_YY_LO,
        SRC_MO_HI,
        SRC_MO_LO,
        SRC_DD_HI,
        SRC_DD_LO,
        SRC_HH_HI,
        SRC_HH_LO,
        SRC_MI_HI,
        SRC_MI_LO,
        SRC_SS_HI,
        SRC_SS_LO,
        SRC_Z
    } t_src;

    // One microcode word
    typedef struct packed {
        t_op  op;
        t_dst dst;
        t_src src;
        logic fin;
        logic jmp;
        t_pc  target;
    } t_uword;

    // Step status from the datapath back to the sequencer
    typedef struct packed {
        logic in_take;
        logic div_done;
        logic year_done;
        logic month_done;
        logic emit_take;
    } t_stat;

    function automatic logic [31:0] recip_const(input t_dst dst);
        logic [31:0] m;
        m = (dst == DST_HOUR) ? RECIP_HOUR : RECIP_MIN_SEC;
        return m;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // Two BCD digits of a value below 100
    function automatic logic [7:0] bcd2(input logic [6:0] v);
        logic [3:0] tens;
        logic [6:0] ones;
        tens = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (v >= 7'(k * 10)) begin
                tens = 4'(k);
            end
        end
        ones = v - ({3'd0, tens} * 7'd10);
        return {tens, ones[3:0]};
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/unix_seconds_to_der_utctime_unit.sv
// Top level of the Unix time to DER UTCTime encoder.
//
// Takes one 32-bit Unix timestamp and emits a 15-byte DER UTCTime element
// (0x17, 0x0D, ASCII YYMMDDHHMMSSZ, year written mod 100), one byte per
// transfer, with o_last_byte set on the closing 'Z'. A small microcode
// program drives one datapath: a reciprocal multiplier splits off
// seconds, minutes and hours, the year walk steps through the elapsed
// years one by one, the month walk through the elapsed months, then
// 15 byte steps emit the element; an output stall holds a byte step.
// One item is in work at a time; o_in_ready rises once the last byte
// sits in the output register.
`default_nettype none

module unix_seconds_to_der_utctime_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_timestamp,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte
);
    import utc_pkg::*;

    t_pc    w_pc;
    t_uword w_word;
    t_stat  w_stat;

    utc_rom u_rom (
        .i_addr (w_pc),
        .o_word (w_word)
    );

    utc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (w_word),
        .i_stat  (w_stat),
        .o_pc    (w_pc)
    );

    utc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (w_word),
        .i_in_valid  (i_in_valid),
        .i_timestamp (i_timestamp),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte),
        .o_stat      (w_stat)
    );

endmodule

`default_nettype wire

>>> hw/rtl/utc_rom.sv
// Microcode store: one control word per program step.
`default_nettype none

module utc_rom (
    input  utc_pkg::t_pc    i_addr,
    output utc_pkg::t_uword o_word
);
    import utc_pkg::*;

    always_comb begin
        unique case (i_addr)
            5'd0:    o_word = '{OP_IDLE,  DST_SEC,  SRC_TAG,   1'b0, 1'b0, PC_IDLE};
            5'd1:    o_word = '{OP_DIV,   DST_SEC,  SRC_TAG,   1'b0, 1'b0, PC_IDLE};
            5'd2:    o_word = '{OP_DIV,   DST_MIN,  SRC_TAG,   1'b0, 1'b0, PC_IDLE};
            5'd3:    o_word = '{OP_DIV,   DST_HOUR, SRC_TAG,   1'b0, 1'b0, PC_IDLE};
            5'd4:    o_word = '{OP_YEAR,  DST_SEC,  SRC_TAG,   1'b0, 1'b0, PC_IDLE};
            5'd5:    o_word = '{OP_MONTH, DST_SEC,  SRC_TAG,   1'b0, 1'b0, PC_IDLE};
            5'd6:    o_word = '{OP_EMIT,  DST_SEC,  SRC_TAG,   1'b0, 1'b0, PC_IDLE};
            5'd7:    o_word = '{OP_EMIT,  DST_SEC,  SRC_LEN,   1'b0, 1'b0, PC_IDLE};
            5'd8:    o_word = '{OP_EMIT,  DST_SEC,  SRC_YY_HI, 1'b0, 1'b0, PC_IDLE};
            5'd9:    o_word = '{OP_EMIT,  DST_SEC,  SRC_YY_LO, 1'b0, 1'b0, PC_IDLE};
            5'd10:   o_word = '{OP_EMIT,  DST_SEC,  SRC_MO_HI, 1'b0, 1'b0, PC_IDLE};
            5'd11:   o_word = '{OP_EMIT,  DST_SEC,  SRC_MO_LO, 1'b0, 1'b0, PC_IDLE};
            5'd12:   o_word = '{OP_EMIT,  DST_SEC,  SRC_DD_HI, 1'b0, 1'b0, PC_IDLE};
            5'd13:   o_word = '{OP_EMIT,  DST_SEC,  SRC_DD_LO, 1'b0, 1'b0, PC_IDLE};
            5'd14:   o_word = '{OP_EMIT,  DST_SEC,  SRC_HH_HI, 1'b0, 1'b0, PC_IDLE};
            5'd15:   o_word = '{OP_EMIT,  DST_SEC,  SRC_HH_LO, 1'b0, 1'b0, PC_IDLE};
            5'd16:   o_word = '{OP_EMIT,  DST_SEC,  SRC_MI_HI, 1'b0, 1'b0, PC_IDLE};
            5'd17:   o_word = '{OP_EMIT,  DST_SEC,  SRC_MI_LO, 1'b0, 1'b0, PC_IDLE};
            5'd18:   o_word = '{OP_EMIT,  DST_SEC,  SRC_SS_HI, 1'b0, 1'b0, PC_IDLE};
            5'd19:   o_word = '{OP_EMIT,  DST_SEC,  SRC_SS_LO, 1'b0, 1'b0, PC_IDLE};
            5'd20:   o_word = '{OP_EMIT,  DST_SEC,  SRC_Z,     1'b1, 1'b1, PC_IDLE};
            default: o_word = '{OP_IDLE,  DST_SEC,  SRC_TAG,   1'b0, 1'b1, PC_IDLE};
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/utc_seq.sv
// Step counter: holds a step until it reports done, then advances or jumps.
`default_nettype none

module utc_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  utc_pkg::t_uword i_word,
    input  utc_pkg::t_stat  i_stat,
    output utc_pkg::t_pc    o_pc
);
    import utc_pkg::*;

    t_pc  r_pc;
    t_pc  n_pc;
    logic w_done;

    always_comb begin
        unique case (i_word.op)
            OP_IDLE:  w_done = i_stat.in_take;
            OP_DIV:   w_done = i_stat.div_done;
            OP_YEAR:  w_done = i_stat.year_done;
            OP_MONTH: w_done = i_stat.month_done;
            OP_EMIT:  w_done = i_stat.emit_take;
            default:  w_done = 1'b1;
        endcase
    end

    always_comb begin
        n_pc = r_pc;
        if (w_done) begin
            n_pc = i_word.jmp ? i_word.target : r_pc + t_pc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_pc = r_pc;

endmodule

`default_nettype wire

>>> hw/rtl/utc_dp.sv
// Datapath: constant divider, calendar walk, digit formatting and output register.
`default_nettype none

module utc_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  utc_pkg::t_uword i_word,
    input  logic            i_in_valid,
    input  logic [31:0]     i_timestamp,
    input  logic            i_out_ready,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output logic [7:0]      o_out_byte,
    output logic            o_last_byte,
    output utc_pkg::t_stat  o_stat
);
    import utc_pkg::*;

    logic [31:0]       r_t;
    logic [63:0]       r_prod;
    logic              r_phase;
    logic [5:0]        r_sec;
    logic [5:0]        r_min;
    logic [4:0]        r_hour;
    logic [1:0]        r_y4;
    logic [6:0]        r_y100;
    logic [8:0]        r_y400;
    logic [3:0]        r_mon;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_last_byte;

    logic        w_in_take;
    logic        w_emit_take;
    logic [31:0] w_recip;
    logic [31:0] w_quot;
    logic [31:0] w_qd;
    logic [5:0]  n_rem;
    logic        w_leap;
    logic [8:0]  w_ylen;
    logic [4:0]  w_mlen;
    logic        w_year_done;
    logic        w_month_done;
    logic        w_div_done;
    logic [6:0]  w_day;
    logic [6:0]  w_pair;
    logic [7:0]  w_digits;
    logic [7:0]  n_byte;

    assign w_in_take   = (i_word.op == OP_IDLE) && i_in_valid;
    assign w_emit_take = !r_out_valid || i_out_ready;

    // Reciprocal divide: multiply, then shift and take the remainder
    assign w_recip = recip_const(i_word.dst);
    assign w_quot  = (i_word.dst == DST_HOUR) ? {4'd0, r_prod[63:36]}
                                              : {5'd0, r_prod[63:37]};
    assign w_qd    = (i_word.dst == DST_HOUR) ? ((w_quot << 4) + (w_quot << 3))
                                              : ((w_quot << 6) - (w_quot << 2));
    assign n_rem   = 6'(r_t - w_qd);
    assign w_div_done = r_phase;

    assign w_leap = ((r_y4 == 2'd0) && (r_y100 != 7'd0)) || (r_y400 == 9'd0);
    assign w_ylen = w_leap ? DAYS_LEAP : DAYS_YEAR;
    assign w_mlen = month_len(r_mon, w_leap);
    assign w_year_done  = (r_t < {23'd0, w_ylen});
    assign w_month_done = (r_mon == MON_DEC) || (r_t < {27'd0, w_mlen});

    assign w_day = {2'd0, r_t[4:0]} + 7'd1;

    always_comb begin
        case (i_word.src) inside
            SRC_YY_HI, SRC_YY_LO: w_pair = r_y100;
            SRC_MO_HI, SRC_MO_LO: w_pair = {3'd0, r_mon};
            SRC_DD_HI, SRC_DD_LO: w_pair = w_day;
            SRC_HH_HI, SRC_HH_LO: w_pair = {2'd0, r_hour};
            SRC_MI_HI, SRC_MI_LO: w_pair = {1'd0, r_min};
            SRC_SS_HI, SRC_SS_LO: w_pair = {1'd0, r_sec};
            default:              w_pair = 7'd0;
        endcase
    end

    assign w_digits = bcd2(w_pair);

    always_comb begin
        case (i_word.src) inside
            SRC_TAG: n_byte = UTC_TAG;
            SRC_LEN: n_byte = UTC_LEN;
            SRC_Z:   n_byte = CH_Z;
            SRC_YY_HI, SRC_MO_HI, SRC_DD_HI, SRC_HH_HI, SRC_MI_HI, SRC_SS_HI:
                     n_byte = CH_ZERO | {4'd0, w_digits[7:4]};
            default: n_byte = CH_ZERO | {4'd0, w_digits[3:0]};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_phase <= 1'b0;
            end else if (i_word.op == OP_DIV) begin
                r_phase <= !r_phase;
            end
            if (i_word.op == OP_EMIT && w_emit_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_word.op)
            OP_IDLE: begin
                if (i_in_valid) begin
                    r_t    <= i_timestamp;
                    r_y4   <= EPOCH_Y4;
                    r_y100 <= EPOCH_Y100;
                    r_y400 <= EPOCH_Y400;
                    r_mon  <= MON_JAN;
                end
            end
            OP_DIV: begin
                if (!r_phase) begin
                    r_prod <= {32'd0, r_t} * {32'd0, w_recip};
                end else begin
                    // Keep the quotient, park the remainder
                    r_t <= w_quot;
                    unique case (i_word.dst)
                        DST_SEC:  r_sec  <= n_rem;
                        DST_MIN:  r_min  <= n_rem;
                        default:  r_hour <= n_rem[4:0];
                    endcase
                end
            end
            OP_YEAR: begin
                if (!w_year_done) begin
                    r_t    <= r_t - {23'd0, w_ylen};
                    r_y4   <= r_y4 + 2'd1;
                    r_y100 <= (r_y100 == Y100_MAX) ? 7'd0 : r_y100 + 7'd1;
                    r_y400 <= (r_y400 == Y400_MAX) ? 9'd0 : r_y400 + 9'd1;
                end
            end
            OP_MONTH: begin
                if (!w_month_done) begin
                    r_t   <= r_t - {27'd0, w_mlen};
                    r_mon <= r_mon + 4'd1;
                end
            end
            OP_EMIT: begin
                if (w_emit_take) begin
                    r_out_byte  <= n_byte;
                    r_last_byte <= i_word.fin;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready  = (i_word.op == OP_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_last_byte;

    assign o_stat = '{
        in_take:    w_in_take,
        div_done:   w_div_done,
        year_done:  w_year_done,
        month_done: w_month_done,
        emit_take:  w_emit_take
    };

endmodule

`default_nettype wire

>>> hw/rtl/utc_chk.sv
// Port-level checker for the UTCTime encoder, bound to the top level.
`default_nettype none

module utc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [31:0] i_timestamp,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_out_byte,
    input logic        o_last_byte
);
    import utc_pkg::*;

    // Stalled output transfer holds its byte
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_last_byte))
        else $error("output changed while stalled");

    // Accepting an input starts work: no second accept next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after accept");

    // While idle, only the closing byte of the previous element may wait
    a_idle_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && o_out_valid |-> o_last_byte)
        else $error("idle with a non-final byte pending");

    // Final byte is always the 'Z' terminator
    a_last_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_byte |-> o_out_byte == CH_Z)
        else $error("final byte is not Z");

endmodule

bind unix_seconds_to_der_utctime_unit utc_chk u_chk (.*);

`default_nettype wire

>>> dv/utctime_checker.sv
// Checker that predicts and compares the DER UTCTime byte stream.
module utctime_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_timestamp,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_byte,
    input  logic        i_last_byte,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] enc_byte;
        logic       last;
    } t_enc_byte;

    t_enc_byte expected_bytes[$];

    function automatic bit is_leap(input int unsigned year);
        return ((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0;
    endfunction

    function automatic int unsigned month_span(input int unsigned year,
                                               input int unsigned mon);
        int unsigned days;
        case (mon)
            2: begin
                days = is_leap(year) ? 29 : 28;
            end
            4, 6, 9, 11: begin
                days = 30;
            end
            default: begin
                days = 31;
            end
        endcase
        return days;
    endfunction

    function automatic void push_byte(input logic [7:0] value, input logic last);
        t_enc_byte entry;
        entry.enc_byte = value;
        entry.last     = last;
        expected_bytes.push_back(entry);
    endfunction

    // Two ASCII decimal digits of a value below 100
    function automatic void push_digits(input int unsigned value);
        push_byte(utc_pkg::CH_ZERO + 8'((value / 10) % 10), 1'b0);
        push_byte(utc_pkg::CH_ZERO + 8'(value % 10), 1'b0);
    endfunction

    function automatic void encode_utctime(input logic [31:0] stamp);
        int unsigned rest;
        int unsigned secs;
        int unsigned mins;
        int unsigned hrs;
        int unsigned year;
        int unsigned mon;
        int unsigned ylen;
        rest = stamp;
        secs = rest % 60;  rest = rest / 60;
        mins = rest % 60;  rest = rest / 60;
        hrs  = rest % 24;  rest = rest / 24;
        year = 1970;
        ylen = is_leap(year) ? 366 : 365;
        while (rest >= ylen) begin
            rest = rest - ylen;
            year++;
            ylen = is_leap(year) ? 366 : 365;
        end
        mon = 1;
        while (mon < 12 && rest >= month_span(year, mon)) begin
            rest = rest - month_span(year, mon);
            mon++;
        end
        push_byte(utc_pkg::UTC_TAG, 1'b0);
        push_byte(utc_pkg::UTC_LEN, 1'b0);
        push_digits(year % 100);
        push_digits(mon);
        push_digits(rest + 1);
        push_digits(hrs);
        push_digits(mins);
        push_digits(secs);
        push_byte(utc_pkg::CH_Z, 1'b1);
    endfunction

    initial begin
        o_fail_count = 0;
    end

    assign o_pending = expected_bytes.size();

    always @(posedge i_clk) begin
        t_enc_byte exp_entry;
        int        errs;
        errs = 0;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                encode_utctime(i_timestamp);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected transfer: out_byte=%h last_byte=%b",
                           i_out_byte, i_last_byte);
                    errs++;
                end else begin
                    exp_entry = expected_bytes.pop_front();
                    if (i_out_byte !== exp_entry.enc_byte) begin
                        $error("out_byte: expected %h, actual %h",
                               exp_entry.enc_byte, i_out_byte);
                        errs++;
                    end
                    if (i_last_byte !== exp_entry.last) begin
                        $error("last_byte: expected %b, actual %b",
                               exp_entry.last, i_last_byte);
                        errs++;
                    end
                end
            end
            if (errs != 0) begin
                o_fail_count <= o_fail_count + errs;
            end
        end
    end

endmodule

>>> dv/tb_top.sv
// Testbench top: stimulus, output back-pressure and verdict for the UTCTime encoder.
module tb_top;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned RANDOM_ITEMS = 400;
    localparam int unsigned QUIET_FROM   = 340;
    localparam int unsigned DRAIN_CYCLES = 300;

    // Calendar landmarks in Unix seconds
    localparam logic [31:0] T_Y2000     = 32'd946684800;
    localparam logic [31:0] T_Y2100     = 32'd4102444800;
    localparam int unsigned SECS_PER_DAY = 86400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_timestamp = 32'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last_byte;

    int          fail_count;
    int          pending;
    int unsigned cycles = 0;
    bit          quiet = 1'b0;

    unix_seconds_to_der_utctime_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_timestamp (i_timestamp),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

    utctime_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_timestamp  (i_timestamp),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_byte   (o_out_byte),
        .i_last_byte  (o_last_byte),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Output back-pressure: random stall bursts, none once the run goes quiet
    initial begin
        int unsigned stall;
        int unsigned run;
        @(negedge i_clk);
        i_out_ready <= 1'b1;
        forever begin
            run = $urandom_range(1, 20);
            repeat (run) @(negedge i_clk);
            if (!quiet && $urandom_range(0, 2) == 0) begin
                stall = $urandom_range(1, 8);
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    // Present one timestamp and hold it until the transfer
    task automatic send_timestamp(input logic [31:0] stamp);
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_timestamp <= stamp;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
    endtask

    // Drop valid for a random burst before the next item
    task automatic sender_gap();
        int unsigned gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic logic [31:0] random_timestamp();
        logic [31:0] stamp;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3: begin
                stamp = $urandom();
            end
            4, 5: begin
                // Around midnight of a random day
                stamp = $urandom_range(0, 49709) * SECS_PER_DAY
                        + $urandom_range(0, 3) - 2;
            end
            6: begin
                stamp = $urandom_range(32'hF000_0000, 32'hFFFF_FFFF);
            end
            7: begin
                stamp = $urandom_range(0, SECS_PER_DAY * 800);
            end
            8: begin
                // Across the start of 2100, a non-leap century year
                stamp = T_Y2100 - SECS_PER_DAY * 100
                        + $urandom_range(0, SECS_PER_DAY * 200);
            end
            default: begin
                // Through the leap year 2000
                stamp = T_Y2000 - SECS_PER_DAY * 2
                        + $urandom_range(0, SECS_PER_DAY * 400);
            end
        endcase
        return stamp;
    endfunction

    initial begin
        logic [31:0] directed[];
        directed = '{
            32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd86399, 32'd86400,
            32'd68169600,                // 1972-02-29
            32'd946684799, T_Y2000,
            32'd951782400, 32'd951868800, // 2000-02-29 and 2000-03-01
            32'd978307199,               // last second of 2000
            32'd2524607999, 32'd2524608000, // end of 2049, start of 2050
            T_Y2100 - 1, T_Y2100,
            32'd4107456000, 32'd4107542400, // 2100-02-28 and 2100-03-01
            32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555
        };
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) begin
            sender_gap();
            send_timestamp(directed[k]);
        end

        // Hold until the directed part has fully drained
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait_drained();

        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                wait_drained();
            end
            if (n == QUIET_FROM) begin
                quiet = 1'b1;
            end
            sender_gap();
            send_timestamp(random_timestamp());
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
